/* hw/rtl/apf_pkg.sv */
// Shared constants, types and the operation table of the area plane fit block.
package apf_pkg;

   localparam int MAX_DIM     = 1024;
   localparam int SAMPLE_W    = 24;
   localparam int COL_W       = $clog2(MAX_DIM);
   localparam int DIM_W       = COL_W + 1;
   localparam int SUM_W       = SAMPLE_W + 2 * COL_W + 1;
   localparam int SUMX_W      = SAMPLE_W + 3 * COL_W + 1;
   localparam int NUM_W       = SAMPLE_W + 4 * COL_W + 16;
   localparam int DEN_W       = 4 * COL_W + 2;
   localparam int OFS_W       = 34;
   localparam int SLP_W       = 42;
   localparam int OFFSET_FRAC = 8;
   localparam int SLOPE_FRAC  = 16;
   localparam int MUL_CNT_W   = $clog2(DIM_W);
   localparam int DIV_CNT_W   = $clog2(NUM_W);
   localparam int MUL_OPS     = 12;
   localparam int MUL_OP_W    = $clog2(MUL_OPS);
   localparam int CSR_ADDR_W  = 3;
   localparam int CSR_DATA_W  = 32;

   localparam logic REG_AREA_WIDTH  = 1'b0;
   localparam logic REG_AREA_HEIGHT = 1'b1;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_MUL_GO,
      ST_MUL_RUN,
      ST_DIV_GO,
      ST_DIV_RUN
   } state_type;

   typedef enum logic [2:0] {
      XS_SUM,
      XS_U,
      XS_KY,
      XS_WIDTH,
      XS_N,
      XS_T
   } xsrc_type;

   typedef enum logic [2:0] {
      MS_W_DEC,
      MS_H_DEC,
      MS_W_INC,
      MS_H_INC,
      MS_H
   } msrc_type;

   typedef enum logic [3:0] {
      DS_KX,
      DS_KY,
      DS_U,
      DS_P,
      DS_NUMA,
      DS_N,
      DS_T,
      DS_DX,
      DS_DY,
      DS_DA
   } dst_type;

   typedef enum logic [1:0] {
      DV_OFFSET,
      DV_SLOPE_X,
      DV_SLOPE_Y
   } div_op_type;

   typedef struct packed {
      xsrc_type xsrc;
      msrc_type msrc;
      dst_type  dst;
   } mul_op_type;

   // The numerator terms come first, then the three denominators.
   function automatic mul_op_type apf_mul_op(input logic [MUL_OP_W-1:0] idx);
      mul_op_type op;
      unique case (idx)
         4'd0:    op = '{XS_SUM,   MS_W_DEC, DS_KX};
         4'd1:    op = '{XS_SUM,   MS_H_DEC, DS_KY};
         4'd2:    op = '{XS_SUM,   MS_W_INC, DS_U};
         4'd3:    op = '{XS_U,     MS_H_INC, DS_P};
         4'd4:    op = '{XS_KY,    MS_W_INC, DS_NUMA};
         4'd5:    op = '{XS_WIDTH, MS_H,     DS_N};
         4'd6:    op = '{XS_N,     MS_W_DEC, DS_T};
         4'd7:    op = '{XS_T,     MS_W_INC, DS_DX};
         4'd8:    op = '{XS_N,     MS_H_DEC, DS_T};
         4'd9:    op = '{XS_T,     MS_H_INC, DS_DY};
         4'd10:   op = '{XS_N,     MS_W_INC, DS_T};
         4'd11:   op = '{XS_T,     MS_H_INC, DS_DA};
         default: op = '{XS_SUM,   MS_W_DEC, DS_KX};
      endcase
      return op;
   endfunction

endpackage

/* hw/rtl/area_plane_fit_top.sv */
// Top level of the area plane fit block: accumulation, sequencing, registers.
//
// Samples of a width by height area are taken one per clock in row-major order
// while busy is low, and the running sums are updated in the same cycle. The
// transaction that carries the last sample of an area starts the fit: busy
// then stays high until the fit is done, which is paced by the shared bit-serial
// multiplier (one factor bit per cycle, twelve products) and the shared
// restoring divider (one quotient bit per cycle, three quotients).
// The result appears for exactly one cycle with rsp_strobe high, on the first
// cycle after busy falls; there is no backpressure on the result side, so the
// receiver must take it then. A new area may start in that same cycle.
// Writing either size register abandons the area in progress.
module area_plane_fit_top (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  start,
   output logic                                  busy,
   input  logic signed [apf_pkg::SAMPLE_W-1:0]   req_sample,
   output logic                                  rsp_strobe,
   output logic signed [apf_pkg::OFS_W-1:0]      rsp_offset_a,
   output logic signed [apf_pkg::SLP_W-1:0]      rsp_slope_x,
   output logic signed [apf_pkg::SLP_W-1:0]      rsp_slope_y,
   input  logic                                  psel,
   input  logic                                  penable,
   input  logic                                  pwrite,
   input  logic        [apf_pkg::CSR_ADDR_W-1:0] paddr,
   input  logic        [apf_pkg::CSR_DATA_W-1:0] pwdata,
   output logic        [apf_pkg::CSR_DATA_W-1:0] prdata,
   output logic                                  pready
);
   import apf_pkg::*;

   state_type state_ff, state_in;

   logic [DIM_W-1:0]  width_ff, height_ff;
   logic [DIM_W-1:0]  w_eff, h_eff;
   logic              cfg_write;

   logic [COL_W-1:0]         col_ff, row_ff;
   logic                     col_last, row_last, area_last, accept;
   logic signed [SUM_W-1:0]  sum_ff, sum_in;
   logic signed [SUMX_W-1:0] sumx_ff, sumx_in, sumy_ff, sumy_in;
   logic signed [SAMPLE_W+COL_W:0] v_col, v_row;

   logic signed [NUM_W-1:0] sum_x, sumx_x, sumy_x;
   logic signed [NUM_W-1:0] kx_ff, ky_ff, u_ff, p_ff, numa_ff;
   logic [DEN_W-1:0]        n_ff, t_ff, dx_ff, dy_ff, da_ff;

   logic [MUL_OP_W-1:0]     op_ff;
   mul_op_type              mop;
   logic signed [NUM_W-1:0] mul_x, mul_prod;
   logic [DIM_W-1:0]        mul_m;
   logic                    mul_go, mul_done, mul_wb;

   div_op_type              div_ff;
   logic signed [NUM_W-1:0] div_num;
   logic [DEN_W-1:0]        div_den;
   logic [NUM_W-1:0]        div_quot;
   logic                    div_go, div_done, div_neg, div_wb, finish;

   logic                    strobe_ff;
   logic signed [OFS_W-1:0] offs_ff;
   logic signed [SLP_W-1:0] slx_ff, sly_ff;

   function automatic logic [OFS_W-1:0] sat_offset(input logic [NUM_W-1:0] q,
                                                   input logic neg);
      logic big;
      logic at_lim;
      big    = |q[NUM_W-1:OFS_W-1];
      at_lim = (q == (NUM_W'(1) << (OFS_W - 1)));
      if (neg) begin
         if (big && !at_lim) begin
            return {1'b1, {(OFS_W-1){1'b0}}};
         end
         return ~q[OFS_W-1:0] + 1'b1;
      end else if (big) begin
         return {1'b0, {(OFS_W-1){1'b1}}};
      end
      return q[OFS_W-1:0];
   endfunction

   function automatic logic [SLP_W-1:0] sat_slope(input logic [NUM_W-1:0] q,
                                                  input logic neg);
      logic big;
      logic at_lim;
      big    = |q[NUM_W-1:SLP_W-1];
      at_lim = (q == (NUM_W'(1) << (SLP_W - 1)));
      if (neg) begin
         if (big && !at_lim) begin
            return {1'b1, {(SLP_W-1){1'b0}}};
         end
         return ~q[SLP_W-1:0] + 1'b1;
      end else if (big) begin
         return {1'b0, {(SLP_W-1){1'b1}}};
      end
      return q[SLP_W-1:0];
   endfunction

   // Configuration registers.
   assign cfg_write = psel && penable && pwrite;
   assign pready    = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= DIM_W'(1);
         height_ff <= DIM_W'(1);
      end else if (cfg_write) begin
         unique case (paddr[CSR_ADDR_W-1])
            REG_AREA_WIDTH:  width_ff  <= pwdata[DIM_W-1:0];
            REG_AREA_HEIGHT: height_ff <= pwdata[DIM_W-1:0];
         endcase
      end
   end

   always_comb begin
      unique case (paddr[CSR_ADDR_W-1])
         REG_AREA_WIDTH:  prdata = CSR_DATA_W'(width_ff);
         REG_AREA_HEIGHT: prdata = CSR_DATA_W'(height_ff);
      endcase
   end

   // A size of zero acts as one, and anything above the maximum as the maximum.
   assign w_eff = (width_ff == '0) ? DIM_W'(1) :
                  (width_ff > DIM_W'(MAX_DIM)) ? DIM_W'(MAX_DIM) : width_ff;
   assign h_eff = (height_ff == '0) ? DIM_W'(1) :
                  (height_ff > DIM_W'(MAX_DIM)) ? DIM_W'(MAX_DIM) : height_ff;

   // Accumulation of one sample per transaction.
   assign accept    = start && !busy;
   assign col_last  = (DIM_W'(col_ff) + DIM_W'(1)) >= w_eff;
   assign row_last  = (DIM_W'(row_ff) + DIM_W'(1)) >= h_eff;
   assign area_last = col_last && row_last;

   assign v_col   = req_sample * $signed({1'b0, col_ff});
   assign v_row   = req_sample * $signed({1'b0, row_ff});
   assign sum_in  = sum_ff + {{(SUM_W-SAMPLE_W){req_sample[SAMPLE_W-1]}}, req_sample};
   assign sumx_in = sumx_ff + {{(SUMX_W-SAMPLE_W-COL_W-1){v_col[SAMPLE_W+COL_W]}}, v_col};
   assign sumy_in = sumy_ff + {{(SUMX_W-SAMPLE_W-COL_W-1){v_row[SAMPLE_W+COL_W]}}, v_row};

   always_ff @(posedge clock) begin
      if (reset || cfg_write || finish) begin
         col_ff  <= '0;
         row_ff  <= '0;
         sum_ff  <= '0;
         sumx_ff <= '0;
         sumy_ff <= '0;
      end else if (accept) begin
         sum_ff  <= sum_in;
         sumx_ff <= sumx_in;
         sumy_ff <= sumy_in;
         if (col_last) begin
            col_ff <= '0;
            if (!row_last) begin
               row_ff <= row_ff + 1'b1;
            end
         end else begin
            col_ff <= col_ff + 1'b1;
         end
      end
   end

   // Sequencer.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      busy     = 1'b1;
      mul_go   = 1'b0;
      mul_wb   = 1'b0;
      div_go   = 1'b0;
      div_wb   = 1'b0;
      finish   = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            busy = 1'b0;
            if (start && area_last) begin
               state_in = ST_MUL_GO;
            end
         end
         ST_MUL_GO: begin
            mul_go   = 1'b1;
            state_in = ST_MUL_RUN;
         end
         ST_MUL_RUN: begin
            if (mul_done) begin
               mul_wb   = 1'b1;
               state_in = (op_ff == MUL_OP_W'(MUL_OPS - 1)) ? ST_DIV_GO : ST_MUL_GO;
            end
         end
         ST_DIV_GO: begin
            div_go   = 1'b1;
            state_in = ST_DIV_RUN;
         end
         ST_DIV_RUN: begin
            if (div_done) begin
               div_wb = 1'b1;
               if (div_ff == DV_SLOPE_Y) begin
                  finish   = 1'b1;
                  state_in = ST_IDLE;
               end else begin
                  state_in = ST_DIV_GO;
               end
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         op_ff     <= '0;
         div_ff    <= DV_OFFSET;
         strobe_ff <= 1'b0;
      end else begin
         strobe_ff <= finish;
         if (accept && area_last) begin
            op_ff <= '0;
         end else if (mul_wb) begin
            op_ff <= op_ff + 1'b1;
         end
         if (mul_wb) begin
            div_ff <= DV_OFFSET;
         end else if (div_wb) begin
            unique case (div_ff)
               DV_OFFSET:  div_ff <= DV_SLOPE_X;
               DV_SLOPE_X: div_ff <= DV_SLOPE_Y;
               DV_SLOPE_Y: div_ff <= DV_OFFSET;
               default:    div_ff <= DV_OFFSET;
            endcase
         end
      end
   end

   // Operand selection for the shared multiplier.
   assign sum_x  = {{(NUM_W-SUM_W){sum_ff[SUM_W-1]}}, sum_ff};
   assign sumx_x = {{(NUM_W-SUMX_W){sumx_ff[SUMX_W-1]}}, sumx_ff};
   assign sumy_x = {{(NUM_W-SUMX_W){sumy_ff[SUMX_W-1]}}, sumy_ff};
   assign mop    = apf_mul_op(op_ff);

   always_comb begin
      case (mop.xsrc)
         XS_SUM:   mul_x = sum_x;
         XS_U:     mul_x = u_ff;
         XS_KY:    mul_x = ky_ff;
         XS_WIDTH: mul_x = {{(NUM_W-DIM_W){1'b0}}, w_eff};
         XS_N:     mul_x = {{(NUM_W-DEN_W){1'b0}}, n_ff};
         XS_T:     mul_x = {{(NUM_W-DEN_W){1'b0}}, t_ff};
         default:  mul_x = sum_x;
      endcase
      case (mop.msrc)
         MS_W_DEC: mul_m = w_eff - DIM_W'(1);
         MS_H_DEC: mul_m = h_eff - DIM_W'(1);
         MS_W_INC: mul_m = w_eff + DIM_W'(1);
         MS_H_INC: mul_m = h_eff + DIM_W'(1);
         MS_H:     mul_m = h_eff;
         default:  mul_m = h_eff;
      endcase
   end

   apf_mul u_mul (
      .clock (clock),
      .reset (reset),
      .go    (mul_go),
      .x     (mul_x),
      .m     (mul_m),
      .done  (mul_done),
      .prod  (mul_prod)
   );

   // kx = 2*Sx - S*(W-1), ky likewise; u = S*(W+1) - 3*kx;
   // the offset numerator is 256*(u*(H+1) - 3*ky*(W+1)).
   always_ff @(posedge clock) begin
      if (mul_wb) begin
         case (mop.dst)
            DS_KX:   kx_ff   <= (sumx_x <<< 1) - mul_prod;
            DS_KY:   ky_ff   <= (sumy_x <<< 1) - mul_prod;
            DS_U:    u_ff    <= mul_prod - kx_ff - (kx_ff <<< 1);
            DS_P:    p_ff    <= mul_prod;
            DS_NUMA: numa_ff <= (p_ff - mul_prod - (mul_prod <<< 1)) <<< OFFSET_FRAC;
            DS_N:    n_ff    <= mul_prod[DEN_W-1:0];
            DS_T:    t_ff    <= mul_prod[DEN_W-1:0];
            DS_DX:   dx_ff   <= mul_prod[DEN_W-1:0];
            DS_DY:   dy_ff   <= mul_prod[DEN_W-1:0];
            DS_DA:   da_ff   <= mul_prod[DEN_W-1:0];
            default: begin
            end
         endcase
      end
   end

   // Slope numerators are 6 * 2^16 * k, built from two shifts.
   always_comb begin
      case (div_ff)
         DV_OFFSET: begin
            div_num = numa_ff;
            div_den = da_ff;
         end
         DV_SLOPE_X: begin
            div_num = (kx_ff <<< (SLOPE_FRAC + 2)) + (kx_ff <<< (SLOPE_FRAC + 1));
            div_den = dx_ff;
         end
         DV_SLOPE_Y: begin
            div_num = (ky_ff <<< (SLOPE_FRAC + 2)) + (ky_ff <<< (SLOPE_FRAC + 1));
            div_den = dy_ff;
         end
         default: begin
            div_num = numa_ff;
            div_den = da_ff;
         end
      endcase
   end

   apf_div u_div (
      .clock (clock),
      .reset (reset),
      .go    (div_go),
      .num   (div_num),
      .den   (div_den),
      .done  (div_done),
      .neg   (div_neg),
      .quot  (div_quot)
   );

   // A single column or a single row has no slope along that axis.
   always_ff @(posedge clock) begin
      if (div_wb) begin
         case (div_ff)
            DV_OFFSET:  offs_ff <= sat_offset(div_quot, div_neg);
            DV_SLOPE_X: slx_ff  <= (w_eff == DIM_W'(1)) ? '0 : sat_slope(div_quot, div_neg);
            DV_SLOPE_Y: sly_ff  <= (h_eff == DIM_W'(1)) ? '0 : sat_slope(div_quot, div_neg);
            default: begin
            end
         endcase
      end
   end

   assign rsp_strobe   = strobe_ff;
   assign rsp_offset_a = offs_ff;
   assign rsp_slope_x  = slx_ff;
   assign rsp_slope_y  = sly_ff;

endmodule

/* hw/rtl/apf_mul.sv */
// Bit-serial multiplier: signed wide operand times a small unsigned factor.
module apf_mul (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              go,
   input  logic signed [apf_pkg::NUM_W-1:0]  x,
   input  logic        [apf_pkg::DIM_W-1:0]  m,
   output logic                              done,
   output logic signed [apf_pkg::NUM_W-1:0]  prod
);
   import apf_pkg::*;

   logic signed [NUM_W-1:0]  x_ff;
   logic signed [NUM_W-1:0]  acc_ff;
   logic signed [NUM_W-1:0]  acc_in;
   logic        [DIM_W-1:0]  m_ff;
   logic    [MUL_CNT_W-1:0]  count_ff;
   logic                     running_ff;
   logic                     done_ff;

   // Factor bits are taken most significant first: double, then add.
   assign acc_in = (acc_ff <<< 1) + (m_ff[DIM_W-1] ? x_ff : NUM_W'(0));

   always_ff @(posedge clock) begin
      if (reset) begin
         running_ff <= 1'b0;
         done_ff    <= 1'b0;
         count_ff   <= '0;
      end else begin
         done_ff <= running_ff && (count_ff == '0);
         if (go) begin
            running_ff <= 1'b1;
            count_ff   <= MUL_CNT_W'(DIM_W - 1);
         end else if (running_ff) begin
            count_ff <= count_ff - 1'b1;
            if (count_ff == '0) begin
               running_ff <= 1'b0;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (go) begin
         x_ff   <= x;
         m_ff   <= m;
         acc_ff <= '0;
      end else if (running_ff) begin
         acc_ff <= acc_in;
         m_ff   <= m_ff << 1;
      end
   end

   assign done = done_ff;
   assign prod = acc_ff;

endmodule

/* hw/rtl/apf_div.sv */
// Restoring divider: one quotient bit per cycle, magnitude quotient plus sign.
module apf_div (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              go,
   input  logic signed [apf_pkg::NUM_W-1:0]  num,
   input  logic        [apf_pkg::DEN_W-1:0]  den,
   output logic                              done,
   output logic                              neg,
   output logic        [apf_pkg::NUM_W-1:0]  quot
);
   import apf_pkg::*;

   logic [NUM_W-1:0]      num_mag;
   logic [NUM_W-1:0]      quot_ff;
   logic [DEN_W-1:0]      den_ff;
   logic [DEN_W-1:0]      rem_ff;
   logic [DEN_W-1:0]      rem_in;
   logic [DEN_W:0]        rem_sh;
   logic                  fits;
   logic [DIV_CNT_W-1:0]  count_ff;
   logic                  running_ff;
   logic                  done_ff;
   logic                  neg_ff;

   assign num_mag = num[NUM_W-1] ? ~num + 1'b1 : num;

   // The dividend shifts out of the top of the quotient register while
   // quotient bits shift in at the bottom.
   assign rem_sh = {rem_ff, quot_ff[NUM_W-1]};
   assign fits   = rem_sh >= {1'b0, den_ff};
   assign rem_in = fits ? DEN_W'(rem_sh - {1'b0, den_ff}) : rem_sh[DEN_W-1:0];

   always_ff @(posedge clock) begin
      if (reset) begin
         running_ff <= 1'b0;
         done_ff    <= 1'b0;
         count_ff   <= '0;
      end else begin
         done_ff <= running_ff && (count_ff == '0);
         if (go) begin
            running_ff <= 1'b1;
            count_ff   <= DIV_CNT_W'(NUM_W - 1);
         end else if (running_ff) begin
            count_ff <= count_ff - 1'b1;
            if (count_ff == '0) begin
               running_ff <= 1'b0;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (go) begin
         quot_ff <= num_mag;
         den_ff  <= den;
         rem_ff  <= '0;
         neg_ff  <= num[NUM_W-1];
      end else if (running_ff) begin
         quot_ff <= {quot_ff[NUM_W-2:0], fits};
         rem_ff  <= rem_in;
      end
   end

   assign done = done_ff;
   assign neg  = neg_ff;
   assign quot = quot_ff;

endmodule

/* tb/tb_top.sv */
// Self-checking testbench for the area plane fit block: sample stream in, plane fit out.
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;

   import apf_pkg::*;

   typedef logic signed [127:0] wide_type;

   typedef struct {
      logic signed [OFS_W-1:0] offset_a;
      logic signed [SLP_W-1:0] slope_x;
      logic signed [SLP_W-1:0] slope_y;
   } plane_type;

   localparam logic [CSR_ADDR_W-1:0] WIDTH_ADDR  = {REG_AREA_WIDTH, 2'b00};
   localparam logic [CSR_ADDR_W-1:0] HEIGHT_ADDR = {REG_AREA_HEIGHT, 2'b00};
   localparam logic signed [SAMPLE_W-1:0] SAMPLE_MAX = {1'b0, {(SAMPLE_W-1){1'b1}}};
   localparam logic signed [SAMPLE_W-1:0] SAMPLE_MIN = {1'b1, {(SAMPLE_W-1){1'b0}}};
   localparam int STALL_LIMIT = 4000;
   localparam int DRAIN_CYCLES = 420;

   logic                         clock;
   logic                         reset;
   logic                         start;
   logic                         busy;
   logic signed [SAMPLE_W-1:0]   req_sample;
   logic                         rsp_strobe;
   logic signed [OFS_W-1:0]      rsp_offset_a;
   logic signed [SLP_W-1:0]      rsp_slope_x;
   logic signed [SLP_W-1:0]      rsp_slope_y;
   logic                         psel;
   logic                         penable;
   logic                         pwrite;
   logic [CSR_ADDR_W-1:0]        paddr;
   logic [CSR_DATA_W-1:0]        pwdata;
   logic [CSR_DATA_W-1:0]        prdata;
   logic                         pready;

   // Shadow of the block: size registers, scan position and running sums.
   logic [DIM_W-1:0] cfg_width;
   logic [DIM_W-1:0] cfg_height;
   int               next_col;
   int               next_row;
   wide_type         sum_v;
   wide_type         sum_vc;
   wide_type         sum_vr;
   plane_type        expected_planes[$];

   int fail_count;
   int sent_count;
   int gap_pct;
   int stall_cycles;

   area_plane_fit_top dut (
      .clock        (clock),
      .reset        (reset),
      .start        (start),
      .busy         (busy),
      .req_sample   (req_sample),
      .rsp_strobe   (rsp_strobe),
      .rsp_offset_a (rsp_offset_a),
      .rsp_slope_x  (rsp_slope_x),
      .rsp_slope_y  (rsp_slope_y),
      .psel         (psel),
      .penable      (penable),
      .pwrite       (pwrite),
      .paddr        (paddr),
      .pwdata       (pwdata),
      .prdata       (prdata),
      .pready       (pready)
   );

   always begin
      clock <= 1'b1;
      #4;
      clock <= 1'b0;
      #4;
   end

   function automatic void note_failure(input string msg);
      fail_count++;
      if (fail_count <= 10) begin
         $display("%0t: %s", $realtime, msg);
      end
   endfunction

   function automatic int clamp_dim(input logic [DIM_W-1:0] value);
      if (value == 0) begin
         return 1;
      end
      if (value > MAX_DIM) begin
         return MAX_DIM;
      end
      return int'(value);
   endfunction

   function automatic void clear_sums();
      next_col = 0;
      next_row = 0;
      sum_v    = '0;
      sum_vc   = '0;
      sum_vr   = '0;
   endfunction

   // Quotient truncated toward zero, then clamped to a signed field of the given width.
   function automatic wide_type fit_quotient(input wide_type num, input wide_type den,
                                             input int bits);
      wide_type q;
      wide_type lim;
      q   = num / den;
      lim = wide_type'(1) <<< (bits - 1);
      if (q >= lim) begin
         q = lim - 1;
      end else if (q < -lim) begin
         q = -lim;
      end
      return q;
   endfunction

   // Adds one sample to the sums; on the last sample of an area the fitted plane is queued.
   function automatic void fold_sample(input logic signed [SAMPLE_W-1:0] v);
      wide_type  x;
      wide_type  wd;
      wide_type  ht;
      wide_type  cells;
      wide_type  kx;
      wide_type  ky;
      wide_type  num;
      wide_type  q;
      plane_type p;
      int        w;
      int        h;
      w = clamp_dim(cfg_width);
      h = clamp_dim(cfg_height);
      x = wide_type'(v);
      sum_v  = sum_v + x;
      sum_vc = sum_vc + x * wide_type'(next_col);
      sum_vr = sum_vr + x * wide_type'(next_row);
      if (next_col + 1 < w) begin
         next_col++;
         return;
      end
      next_col = 0;
      if (next_row + 1 < h) begin
         next_row++;
         return;
      end
      wd    = wide_type'(w);
      ht    = wide_type'(h);
      cells = wd * ht;
      kx    = '0;
      ky    = '0;
      if (w > 1) begin
         kx = 2 * sum_vc - sum_v * (wd - 1);
      end
      if (h > 1) begin
         ky = 2 * sum_vr - sum_v * (ht - 1);
      end
      num = sum_v * (wd + 1) * (ht + 1) - 3 * kx * (ht + 1) - 3 * ky * (wd + 1);
      q = fit_quotient(num <<< OFFSET_FRAC, cells * (wd + 1) * (ht + 1), OFS_W);
      p.offset_a = q[OFS_W-1:0];
      p.slope_x  = '0;
      p.slope_y  = '0;
      if (w > 1) begin
         q = fit_quotient((kx * 6) <<< SLOPE_FRAC, cells * (wd * wd - 1), SLP_W);
         p.slope_x = q[SLP_W-1:0];
      end
      if (h > 1) begin
         q = fit_quotient((ky * 6) <<< SLOPE_FRAC, cells * (ht * ht - 1), SLP_W);
         p.slope_y = q[SLP_W-1:0];
      end
      expected_planes.push_back(p);
      clear_sums();
   endfunction

   function automatic logic signed [SAMPLE_W-1:0] pick_sample();
      logic signed [SAMPLE_W-1:0] v;
      v = SAMPLE_W'($urandom);
      case ($urandom_range(0, 9))
         0: begin
            v = SAMPLE_MIN;
         end
         1: begin
            v = SAMPLE_MAX;
         end
         2: begin
            v = $urandom_range(0, 1) ? '0 : '1;
         end
         3, 4: begin
            v = SAMPLE_W'(int'($urandom_range(0, 2000)) - 1000);
         end
         default: begin
         end
      endcase
      return v;
   endfunction

   // Holds start high until the block takes the sample; start is left high on return.
   task automatic send_sample(input logic signed [SAMPLE_W-1:0] v);
      while ($urandom_range(0, 99) < gap_pct) begin
         start      <= 1'b0;
         req_sample <= SAMPLE_W'($urandom);
         @(posedge clock);
      end
      start      <= 1'b1;
      req_sample <= v;
      do @(posedge clock); while (busy);
      fold_sample(v);
      sent_count++;
   endtask

   task automatic wait_idle();
      start <= 1'b0;
      while (expected_planes.size() != 0 || busy) begin
         @(posedge clock);
      end
      repeat (4) @(posedge clock);
   endtask

   task automatic read_reg(input logic [CSR_ADDR_W-1:0] addr, input logic [DIM_W-1:0] want);
      logic [CSR_DATA_W-1:0] got;
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b0;
      paddr   <= addr;
      @(posedge clock);
      penable <= 1'b1;
      @(negedge clock);
      got = prdata;
      @(posedge clock);
      psel    <= 1'b0;
      penable <= 1'b0;
      @(posedge clock);
      if (got !== CSR_DATA_W'(want)) begin
         note_failure($sformatf("register read mismatch at address %0d: expected %0d, got %0h",
                                addr, want, got));
      end
   endtask

   // Writes a size register with random upper data bits, then reads it back.
   task automatic set_reg(input logic [CSR_ADDR_W-1:0] addr, input logic [DIM_W-1:0] value);
      logic [CSR_DATA_W-1:0] data;
      data = $urandom;
      data[DIM_W-1:0] = value;
      start   <= 1'b0;
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= addr;
      pwdata  <= data;
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      if (addr == WIDTH_ADDR) begin
         cfg_width = value;
      end else begin
         cfg_height = value;
      end
      clear_sums();
      read_reg(addr, value);
   endtask

   task automatic test_reset_and_single_sample();
      read_reg(WIDTH_ADDR, 1);
      read_reg(HEIGHT_ADDR, 1);
      send_sample(SAMPLE_MAX);
      send_sample(SAMPLE_MIN);
      send_sample('0);
   endtask

   task automatic test_single_row();
      wait_idle();
      set_reg(WIDTH_ADDR, 4);
      set_reg(HEIGHT_ADDR, 1);
      send_sample(SAMPLE_MAX);
      send_sample(SAMPLE_MIN);
      send_sample('1);
      send_sample(SAMPLE_MAX);
   endtask

   task automatic test_single_column();
      wait_idle();
      set_reg(WIDTH_ADDR, 1);
      set_reg(HEIGHT_ADDR, 4);
      send_sample(SAMPLE_MIN);
      send_sample(SAMPLE_MAX);
      send_sample(1);
      send_sample(SAMPLE_MIN);
   endtask

   // Alternating extremes across two columns give the steepest slope in x.
   task automatic test_two_by_two();
      wait_idle();
      set_reg(WIDTH_ADDR, 2);
      set_reg(HEIGHT_ADDR, 2);
      send_sample(SAMPLE_MIN);
      send_sample(SAMPLE_MAX);
      send_sample(SAMPLE_MIN);
      send_sample(SAMPLE_MAX);
   endtask

   task automatic test_dimension_clamp();
      wait_idle();
      set_reg(WIDTH_ADDR, 0);
      set_reg(HEIGHT_ADDR, 0);
      send_sample(pick_sample());
   endtask

   // A register write in the middle of an area throws away the partial sums.
   task automatic test_abandon_area();
      wait_idle();
      set_reg(WIDTH_ADDR, 3);
      set_reg(HEIGHT_ADDR, 2);
      repeat (3) send_sample(pick_sample());
      wait_idle();
      set_reg(WIDTH_ADDR, 3);
      repeat (6) send_sample(pick_sample());
   endtask

   task automatic test_random_areas(input int gap, input int goal);
      int first;
      int w;
      int h;
      int areas;
      int cells;
      gap_pct = gap;
      first   = sent_count;
      while (sent_count - first < goal) begin
         case ($urandom_range(0, 7))
            0: begin
               w = $urandom_range(13, 80);
               h = $urandom_range(0, 2);
            end
            1: begin
               w = $urandom_range(0, 2);
               h = $urandom_range(13, 80);
            end
            default: begin
               w = $urandom_range(0, 6);
               h = $urandom_range(0, 6);
            end
         endcase
         wait_idle();
         if ($urandom_range(0, 3) != 0) begin
            set_reg(WIDTH_ADDR, DIM_W'(w));
         end
         set_reg(HEIGHT_ADDR, DIM_W'(h));
         areas = $urandom_range(1, 3);
         for (int a = 0; a < areas; a++) begin
            cells = clamp_dim(cfg_width) * clamp_dim(cfg_height);
            // Now and then the last area stays unfinished and the next write drops it.
            if (a == areas - 1 && $urandom_range(0, 5) == 0) begin
               cells = $urandom_range(1, cells) - 1;
            end
            repeat (cells) send_sample(pick_sample());
         end
      end
   endtask

   task automatic test_largest_area();
      wait_idle();
      set_reg(WIDTH_ADDR, '1);
      set_reg(HEIGHT_ADDR, 0);
      repeat (MAX_DIM) send_sample(pick_sample());
   endtask

   always @(posedge clock) begin : check_results
      plane_type want;
      if (!reset && rsp_strobe) begin
         if (expected_planes.size() == 0) begin
            note_failure($sformatf("unexpected plane: offset %0d slope_x %0d slope_y %0d",
                                   rsp_offset_a, rsp_slope_x, rsp_slope_y));
         end else begin
            want = expected_planes.pop_front();
            if (rsp_offset_a !== want.offset_a || rsp_slope_x !== want.slope_x ||
                rsp_slope_y !== want.slope_y) begin
               note_failure($sformatf(
                  "plane mismatch: expected offset %0d slope_x %0d slope_y %0d, got %0d %0d %0d",
                  want.offset_a, want.slope_x, want.slope_y,
                  rsp_offset_a, rsp_slope_x, rsp_slope_y));
            end
         end
      end
   end

   // Ends the run when no transaction of any kind has completed for too long.
   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_strobe || (psel && penable)) begin
         stall_cycles <= 0;
      end else begin
         stall_cycles <= stall_cycles + 1;
         if (stall_cycles >= STALL_LIMIT) begin
            $display("TEST FAILED");
            $finish;
         end
      end
   end

   initial begin
      reset      <= 1'b1;
      start      <= 1'b0;
      req_sample <= '0;
      psel       <= 1'b0;
      penable    <= 1'b0;
      pwrite     <= 1'b0;
      paddr      <= '0;
      pwdata     <= '0;
      cfg_width  = 1;
      cfg_height = 1;
      clear_sums();
      fail_count   = 0;
      sent_count   = 0;
      gap_pct      = 36;
      stall_cycles = 0;
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_reset_and_single_sample();
      test_single_row();
      test_single_column();
      test_two_by_two();
      test_dimension_clamp();
      test_abandon_area();
      test_random_areas(36, 270);
      test_random_areas(51, 270);
      test_random_areas(0, 270);
      test_largest_area();

      start <= 1'b0;
      while (expected_planes.size() != 0) begin
         @(posedge clock);
      end
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (fail_count == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

endmodule

/* sim.f */
hw/rtl/apf_pkg.sv
hw/rtl/apf_mul.sv
hw/rtl/apf_div.sv
hw/rtl/area_plane_fit_top.sv
tb/tb_top.sv
